@@ rtl/alpd_pkg.sv @@
`default_nettype none
package alpd_pkg;

    localparam int COORD_W = 32;
    localparam int LEN_W   = 31;
    localparam int CURV_W  = 32;
    localparam int TURN_W  = 32;
    localparam int FRAC_W  = 32;
    localparam int CORD_W  = 34;

    localparam logic [2:0] REG_START_X       = 3'd0;
    localparam logic [2:0] REG_START_Y       = 3'd1;
    localparam logic [2:0] REG_START_HEADING = 3'd2;
    localparam logic [2:0] REG_SEGMENT_LEN   = 3'd3;
    localparam logic [2:0] REG_CURVATURE     = 3'd4;
    localparam logic [2:0] REG_SEGMENT_KIND  = 3'd5;

    localparam logic [CORD_W-1:0] CORDIC_GAIN_Q30 = CORD_W'(652032874);
    localparam logic [54:0] INV_PI_Q54 = 55'h145F306DC9C883;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] t [32];
        t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
              32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
              32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
              32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
              32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
              32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
        return t[idx & 31];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [47:0] v);
        logic signed [COORD_W-1:0] r;
        r = v[COORD_W-1:0];
        if (v > 48'sh00007FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -48'sh000080000000)
            r = -32'sh80000000;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/alpd_if.sv @@
`default_nettype none
interface alpd_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       distance;
    modport source (output valid, output distance, input ready);
    modport sink (input valid, input distance, output ready);
endinterface

interface alpd_out_if #(parameter int ANGLE_BITS = 16);
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       point_x;
    logic signed [31:0]       point_y;
    logic [ANGLE_BITS-1:0]    tangent;
    modport source (output valid, output point_x, output point_y, output tangent,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input tangent,
                  output ready);
endinterface

interface alpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/arc_line_point_at_distance_unit.sv @@
`default_nettype none
// Point and tangent at an arc length along one planar road segment (straight
// line or circular arc) held in six configuration registers. Each distance
// transfer yields exactly one result transfer, in order. The datapath is a
// single pipeline that accepts one distance every cycle while the output is
// not stalled: a clamp and curvature multiply front end (four stages), a
// half-angle CORDIC (CORDIC_STAGES+1), a chord divider (47 stages), a
// heading CORDIC (CORDIC_STAGES+1) and a two-stage scale, add and saturate
// back end whose last stage is the output register. A stall at the output
// freezes the whole pipeline, and input ready drops only when the output
// register is full and not being drained. Configuration must be written
// only while the pipeline is empty. Straight lines and zero-curvature arcs
// travel the same path with the chord equal to the clamped distance and
// zero turn.
module arc_line_point_at_distance_unit #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    alpd_cfg_if.sink      cfg,
    alpd_in_if.sink       in_ch,
    alpd_out_if.source    out_ch
);
    localparam int NUM_W = 46;

    logic signed [31:0]    start_x_reg, start_y_reg, curvature_reg;
    logic [ANGLE_BITS-1:0] start_heading_reg;
    logic [30:0]           segment_length_reg;
    logic                  segment_kind_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg        <= '0;
            start_y_reg        <= '0;
            start_heading_reg  <= '0;
            segment_length_reg <= '0;
            curvature_reg      <= '0;
            segment_kind_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                alpd_pkg::REG_START_X:       start_x_reg <= cfg.data;
                alpd_pkg::REG_START_Y:       start_y_reg <= cfg.data;
                alpd_pkg::REG_START_HEADING: start_heading_reg <= cfg.data[ANGLE_BITS-1:0];
                alpd_pkg::REG_SEGMENT_LEN:   segment_length_reg <= cfg.data[30:0];
                alpd_pkg::REG_CURVATURE:     curvature_reg <= cfg.data;
                alpd_pkg::REG_SEGMENT_KIND:  segment_kind_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the output register can take a result.
    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    logic [31:0] h32;
    logic        is_arc;
    assign h32    = {start_heading_reg, {(32-ANGLE_BITS){1'b0}}};
    assign is_arc = segment_kind_reg && (curvature_reg != '0);

    // Stage 1: clamp.
    logic        s1_v_reg;
    logic [30:0] s1_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_ch.valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_ch.distance[31])
                s1_d_reg <= '0;
            else if (in_ch.distance[30:0] > segment_length_reg)
                s1_d_reg <= segment_length_reg;
            else
                s1_d_reg <= in_ch.distance[30:0];
        end
    end

    // Stage 2: |d*k| (31x32 product) and its sign.
    logic        s2_v_reg, s2_neg_reg;
    logic [30:0] s2_d_reg;
    logic [61:0] s2_m_reg;
    logic [31:0] kabs;
    assign kabs = curvature_reg[31] ? 32'(-curvature_reg) : 32'(curvature_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_m_reg   <= 62'(s1_d_reg) * 62'(kabs);
            s2_neg_reg <= curvature_reg[31] && (s1_d_reg != '0);
            s2_d_reg   <= s1_d_reg;
        end
    end

    // Stage 3: m * (2^54/pi) as four partial products, each within 31x27 bits.
    logic [26:0] inv_lo;
    logic [25:0] inv_hi;
    assign inv_lo = alpd_pkg::INV_PI_Q54[26:0];
    assign inv_hi = alpd_pkg::INV_PI_Q54[52:27];

    logic        s3_v_reg, s3_neg_reg;
    logic [30:0] s3_d_reg;
    logic [57:0] s3_ll_reg, s3_hl_reg;
    logic [56:0] s3_lh_reg, s3_hh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ll_reg  <= 58'(s2_m_reg[30:0]) * 58'(inv_lo);
            s3_lh_reg  <= 57'(s2_m_reg[30:0]) * 57'(inv_hi);
            s3_hl_reg  <= 58'(s2_m_reg[61:31]) * 58'(inv_lo);
            s3_hh_reg  <= 57'(s2_m_reg[61:31]) * 57'(inv_hi);
            s3_neg_reg <= s2_neg_reg;
            s3_d_reg   <= s2_d_reg;
        end
    end

    // Stage 4: sum the partial products; psi magnitude is bits 64..95.
    logic [95:0] prod_sum;
    assign prod_sum = 96'(s3_ll_reg) + (96'(s3_lh_reg) << 27)
                    + (96'(s3_hl_reg) << 31) + (96'(s3_hh_reg) << 58);

    logic        s4_v_reg, s4_neg_reg;
    logic [30:0] s4_d_reg;
    logic [31:0] s4_mag_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (en)
            s4_v_reg <= s3_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_mag_reg <= prod_sum[95:64];
            s4_neg_reg <= s3_neg_reg;
            s4_d_reg   <= s3_d_reg;
        end
    end

    logic [31:0] psi;
    assign psi = is_arc ? (s4_neg_reg ? 32'(-s4_mag_reg) : s4_mag_reg) : '0;

    // Half-angle CORDIC; the tag carries psi and the distance.
    localparam int TAG1 = 63;
    logic              c1_v;
    logic signed [alpd_pkg::CORD_W-1:0] c1_cos, c1_sin;
    logic [TAG1-1:0]   c1_tag;
    alpd_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(TAG1)) u_cordic_half (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s4_v_reg), .in_angle(psi), .in_tag({psi, s4_d_reg}),
        .out_valid(c1_v), .out_cos(c1_cos), .out_sin(c1_sin), .out_tag(c1_tag)
    );

    // Chord = sin(psi)*2^11 / k.
    logic signed [NUM_W-1:0] num;
    logic signed [31:0]      den;
    assign num = is_arc ? NUM_W'(c1_sin) <<< 11 : '0;
    assign den = is_arc ? curvature_reg : 32'sd1;

    logic              dv_v;
    logic signed [NUM_W:0] dv_q;
    logic [TAG1-1:0]   dv_tag;
    alpd_divider #(.NUM_W(NUM_W), .DEN_W(32), .TAG_W(TAG1)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(c1_v), .in_num(num), .in_den(den), .in_tag(c1_tag),
        .out_valid(dv_v), .out_quot(dv_q), .out_tag(dv_tag)
    );

    logic [31:0]         dv_psi;
    logic [30:0]         dv_d;
    logic signed [NUM_W:0] d_s;
    logic signed [32:0]  chord;
    assign dv_psi = dv_tag[TAG1-1:31];
    assign dv_d   = dv_tag[30:0];
    assign d_s    = $signed({{(NUM_W-30){1'b0}}, dv_d});
    always_comb
    begin
        if (!is_arc)
            chord = $signed({2'b00, dv_d});
        else if (dv_q > d_s)
            chord = $signed({2'b00, dv_d});
        else if (dv_q < -d_s)
            chord = -$signed({2'b00, dv_d});
        else
            chord = 33'(dv_q);
    end

    // Heading CORDIC at h + psi; tag carries chord and the turn angle.
    localparam int TAG2 = 65;
    logic [31:0]       theta;
    assign theta = {dv_psi[30:0], 1'b0};
    logic              c2_v;
    logic signed [alpd_pkg::CORD_W-1:0] c2_cos, c2_sin;
    logic [TAG2-1:0]   c2_tag;
    alpd_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(TAG2)) u_cordic_head (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(dv_v), .in_angle(h32 + dv_psi), .in_tag({chord, theta}),
        .out_valid(c2_v), .out_cos(c2_cos), .out_sin(c2_sin), .out_tag(c2_tag)
    );

    // Back end stage A: products.
    logic                b1_v_reg;
    logic signed [66:0]  b1_px_reg, b1_py_reg;
    logic [31:0]         b1_theta_reg;
    logic signed [32:0]  c2_chord;
    assign c2_chord = $signed(c2_tag[TAG2-1:32]);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b1_v_reg <= 1'b0;
        else if (en)
            b1_v_reg <= c2_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_px_reg    <= 67'(c2_chord) * 67'(c2_cos);
            b1_py_reg    <= 67'(c2_chord) * 67'(c2_sin);
            b1_theta_reg <= c2_tag[31:0];
        end
    end

    // Stage B: round, add start, saturate; tangent.
    logic signed [66:0] rx, ry;
    assign rx = (b1_px_reg + 67'sd536870912) >>> 30;
    assign ry = (b1_py_reg + 67'sd536870912) >>> 30;
    logic [31:0] tsum;
    assign tsum = h32 + b1_theta_reg + (32'd1 << (31 - ANGLE_BITS));

    logic signed [31:0]    out_x_reg, out_y_reg;
    logic [ANGLE_BITS-1:0] out_t_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= b1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg <= alpd_pkg::sat32(48'(rx) + 48'(start_x_reg));
            out_y_reg <= alpd_pkg::sat32(48'(ry) + 48'(start_y_reg));
            out_t_reg <= tsum[31:32-ANGLE_BITS];
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.point_x = out_x_reg;
    assign out_ch.point_y = out_y_reg;
    assign out_ch.tangent = out_t_reg;
endmodule
`default_nettype wire

@@ rtl/alpd_cordic.sv @@
`default_nettype none
// Pipelined rotation CORDIC: one register stage per micro-rotation. A tag
// rides along untouched so callers can keep per-item data aligned.
module alpd_cordic #(
    parameter int STAGES = 18,
    parameter int TAG_W  = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [31:0]             in_angle,
    input  wire logic [TAG_W-1:0]        in_tag,
    output logic                         out_valid,
    output logic signed [alpd_pkg::CORD_W-1:0] out_cos,
    output logic signed [alpd_pkg::CORD_W-1:0] out_sin,
    output logic [TAG_W-1:0]             out_tag
);
    localparam int W = alpd_pkg::CORD_W;

    logic signed [W-1:0]  x_reg [STAGES+1];
    logic signed [W-1:0]  y_reg [STAGES+1];
    logic signed [W-1:0]  z_reg [STAGES+1];
    logic [1:0]           q_reg [STAGES+1];
    logic [TAG_W-1:0]     tag_reg [STAGES+1];
    logic [STAGES:0]      v_reg;

    logic [31:0] a_rot;
    assign a_rot = in_angle + 32'h20000000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[STAGES-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= alpd_pkg::CORDIC_GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= W'($signed({2'b00, a_rot[29:0]})) - W'(32'sh20000000);
            q_reg[0]   <= a_rot[31:30];
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - W'(alpd_pkg::atan_turn(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + W'(alpd_pkg::atan_turn(i));
                end
                q_reg[i+1]   <= q_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    always_comb
    begin
        unique case (q_reg[STAGES])
            2'd0:
            begin
                out_cos = x_reg[STAGES];
                out_sin = y_reg[STAGES];
            end
            2'd1:
            begin
                out_cos = -y_reg[STAGES];
                out_sin = x_reg[STAGES];
            end
            2'd2:
            begin
                out_cos = -x_reg[STAGES];
                out_sin = -y_reg[STAGES];
            end
            default:
            begin
                out_cos = y_reg[STAGES];
                out_sin = -x_reg[STAGES];
            end
        endcase
    end

    assign out_valid = v_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];
endmodule
`default_nettype wire

@@ rtl/alpd_divider.sv @@
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, truncating toward
// zero. Works on magnitudes; the quotient sign is applied at the end.
module alpd_divider #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 32,
    parameter int TAG_W = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic signed [NUM_W-1:0] in_num,
    input  wire logic signed [DEN_W-1:0] in_den,
    input  wire logic [TAG_W-1:0]        in_tag,
    output logic                         out_valid,
    output logic signed [NUM_W:0]        out_quot,
    output logic [TAG_W-1:0]             out_tag
);
    localparam int RW = DEN_W + 1;

    logic [NUM_W-1:0]  n_reg   [NUM_W+1];
    logic [NUM_W-1:0]  q_reg   [NUM_W+1];
    logic [RW-1:0]     r_reg   [NUM_W+1];
    logic [DEN_W-1:0]  d_reg   [NUM_W+1];
    logic              neg_reg [NUM_W+1];
    logic [TAG_W-1:0]  tag_reg [NUM_W+1];
    logic [NUM_W:0]    v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NUM_W-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
            d_reg[0]   <= in_den[DEN_W-1] ? DEN_W'(-in_den) : DEN_W'(in_den);
            neg_reg[0] <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
            q_reg[0]   <= '0;
            r_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_step
        logic [RW-1:0] trial;
        logic [RW:0]   diff;
        assign trial = {r_reg[i][RW-2:0], n_reg[i][NUM_W-1-i]};
        assign diff  = {1'b0, trial} - {2'b00, d_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!diff[RW])
                begin
                    r_reg[i+1] <= diff[RW-1:0];
                    q_reg[i+1] <= q_reg[i] | (NUM_W'(1) << (NUM_W-1-i));
                end
                else
                begin
                    r_reg[i+1] <= trial;
                    q_reg[i+1] <= q_reg[i];
                end
                n_reg[i+1]   <= n_reg[i];
                d_reg[i+1]   <= d_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign out_quot  = neg_reg[NUM_W] ? -$signed({1'b0, q_reg[NUM_W]})
                                      : $signed({1'b0, q_reg[NUM_W]});
    assign out_tag   = tag_reg[NUM_W];
endmodule
`default_nettype wire
